FILE: rtl/core/mchs_pkg.sv
// shared types and constants for the merge conflict hunk scanner
// no dependencies; imported by the top level

package mchs_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int OUT_W = 32;

	localparam logic [7:0] CH_START = 8'h3C;  // '<'
	localparam logic [7:0] CH_BASE = 8'h7C;   // '|'
	localparam logic [7:0] CH_SEP = 8'h3D;    // '='
	localparam logic [7:0] CH_END = 8'h3E;    // '>'
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [2:0] MARK_LEN = 3'd7;

	typedef enum logic [1:0] {
		K_START = 2'd0,
		K_BASE = 2'd1,
		K_SEP = 2'd2,
		K_END = 2'd3
	} mark_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_OURS = 2'd1,
		PH_BASE = 2'd2,
		PH_THEIRS = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		AW_NONE = 2'd0,
		AW_START = 2'd1,
		AW_BASE = 2'd2,
		AW_END = 2'd3
	} await_t;

	function automatic logic [7:0] mark_char(input mark_kind_t k);
		logic [7:0] c;
		case (k)
			K_START: c = CH_START;
			K_BASE: c = CH_BASE;
			K_SEP: c = CH_SEP;
			K_END: c = CH_END;
			default: c = CH_START;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/mchs_ifs.sv
// valid/ready channel interfaces for the merge conflict hunk scanner
// text byte channel and hunk record channel; no dependencies

interface mchs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source(output valid, text_byte, last_byte, input ready);
	modport sink(input valid, text_byte, last_byte, output ready);
endinterface

interface mchs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hunk_start;
	logic [31:0] hunk_end;
	logic [31:0] ours_start;
	logic [31:0] ours_end;
	logic        has_base;
	logic [31:0] base_start;
	logic [31:0] base_end;
	logic [31:0] theirs_start;
	logic [31:0] theirs_end;

	modport source(output valid, hunk_start, hunk_end, ours_start, ours_end, has_base,
		base_start, base_end, theirs_start, theirs_end, input ready);
	modport sink(input valid, hunk_start, hunk_end, ours_start, ours_end, has_base,
		base_start, base_end, theirs_start, theirs_end, output ready);
endinterface

FILE: rtl/core/merge_conflict_hunk_scanner.sv
// Scans a byte stream for merge conflict markers at line starts and gives one
// record per complete hunk with the byte offsets of its sections. One byte is
// taken per clock cycle while the scanner does not stall; a byte goes into an
// input register, from which the marker matcher and hunk tracker update the
// scan state and any record lands in the output register. The scanner stalls
// only while a record waits in the output register and the sink holds off.
// Offsets count in OFFSET_BITS bits, stop at the top value, and are reported
// in their low 32 bits. After a byte marked last_byte all scan state returns
// to its reset value.
// Depends on mchs_pkg and the channel interfaces in mchs_ifs.sv.

module merge_conflict_hunk_scanner #(
	parameter int OFFSET_BITS = mchs_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mchs_in_if.sink           text_in,
	mchs_out_if.source        hunk_out
);
	import mchs_pkg::*;

	localparam int OB = OFFSET_BITS;
	typedef logic [OB-1:0] ofs_t;
	localparam ofs_t OFS_TOP = {OB{1'b1}};
	localparam ofs_t OFS_MARK = OB'(7);
	localparam ofs_t OFS_SEP_LINE = OB'(8);

	function automatic logic [OUT_W-1:0] to_out(input ofs_t v);
		logic [OB+OUT_W-1:0] wide;
		wide = {{OUT_W{1'b0}}, v};
		return wide[OUT_W-1:0];
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// scan state
	ofs_t       offset_q;
	logic       line_start_q;
	logic [2:0] progress_q;
	mark_kind_t kind_q;
	phase_t     phase_q;
	await_t     await_q;
	ofs_t       hunk_start_q;
	ofs_t       ours_start_q;
	ofs_t       ours_end_q;
	logic       has_base_q;
	ofs_t       base_start_q;
	ofs_t       theirs_start_q;
	ofs_t       theirs_end_q;

	// result register
	logic              out_valid_q;
	logic [OUT_W-1:0]  r_hunk_start_q, r_hunk_end_q, r_ours_start_q, r_ours_end_q;
	logic              r_has_base_q;
	logic [OUT_W-1:0]  r_base_start_q, r_base_end_q, r_theirs_start_q, r_theirs_end_q;

	logic advance;
	logic emit;

	ofs_t       nxt_ofs, mpos;
	logic       is_nl, ev_valid;
	mark_kind_t ev_kind;

	ofs_t       n_offset;
	logic       n_line_start;
	logic [2:0] n_progress;
	mark_kind_t n_kind;
	phase_t     n_phase;
	await_t     n_await;
	ofs_t       n_hunk_start, n_ours_start, n_ours_end, n_base_start;
	ofs_t       n_theirs_start, n_theirs_end;
	logic       n_has_base;

	assign advance = valid_s1 && (!out_valid_q || hunk_out.ready);
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			last_s1 <= text_in.last_byte;
		end
	end

	always_comb begin
		nxt_ofs = (offset_q == OFS_TOP) ? offset_q : offset_q + OB'(1);
		mpos = offset_q - OFS_MARK;
		is_nl = (byte_s1 == CH_NL);
		ev_valid = 1'b0;
		ev_kind = kind_q;

		n_offset = nxt_ofs;
		n_line_start = is_nl;
		n_progress = 3'd0;
		n_kind = kind_q;
		n_phase = phase_q;
		n_await = await_q;
		n_hunk_start = hunk_start_q;
		n_ours_start = ours_start_q;
		n_ours_end = ours_end_q;
		n_has_base = has_base_q;
		n_base_start = base_start_q;
		n_theirs_start = theirs_start_q;
		n_theirs_end = theirs_end_q;

		// marker matching
		if (line_start_q) begin
			case (byte_s1)
				CH_START: begin
					n_kind = K_START;
					n_progress = 3'd1;
				end
				CH_BASE: begin
					n_kind = K_BASE;
					n_progress = 3'd1;
				end
				CH_SEP: begin
					n_kind = K_SEP;
					n_progress = 3'd1;
				end
				CH_END: begin
					n_kind = K_END;
					n_progress = 3'd1;
				end
				default: n_progress = 3'd0;
			endcase
		end else if (progress_q != 3'd0 && progress_q != MARK_LEN) begin
			n_progress = (byte_s1 == mark_char(kind_q)) ? progress_q + 3'd1 : 3'd0;
		end else if (progress_q == MARK_LEN) begin
			// separator needs a bare line, the others a following space
			ev_valid = (kind_q == K_SEP) ? is_nl : (byte_s1 == CH_SP);
		end

		// hunk tracking
		if (ev_valid) begin
			case (ev_kind)
				K_START: begin
					n_hunk_start = mpos;
					n_has_base = 1'b0;
					n_base_start = '0;
					n_phase = PH_OURS;
					n_await = AW_START;
				end
				K_BASE: begin
					if (phase_q == PH_OURS) begin
						n_ours_end = mpos;
						n_has_base = 1'b1;
						n_phase = PH_BASE;
						n_await = AW_BASE;
					end
				end
				K_SEP: begin
					if (phase_q == PH_OURS || phase_q == PH_BASE) begin
						if (phase_q == PH_OURS) begin
							n_ours_end = mpos;
						end
						n_theirs_start = nxt_ofs;
						n_phase = PH_THEIRS;
					end
				end
				K_END: begin
					if (phase_q == PH_THEIRS) begin
						n_theirs_end = mpos;
						n_await = AW_END;
					end
				end
				default: n_phase = phase_q;
			endcase
		end

		if (is_nl && n_await == AW_START) begin
			n_ours_start = nxt_ofs;
			n_await = AW_NONE;
		end else if (is_nl && n_await == AW_BASE) begin
			n_base_start = nxt_ofs;
			n_await = AW_NONE;
		end

		emit = (n_await == AW_END) && (is_nl || last_s1);
		if (emit) begin
			n_phase = PH_IDLE;
			n_await = AW_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			line_start_q <= 1'b1;
			progress_q <= 3'd0;
			kind_q <= K_START;
			phase_q <= PH_IDLE;
			await_q <= AW_NONE;
			hunk_start_q <= '0;
			ours_start_q <= '0;
			ours_end_q <= '0;
			has_base_q <= 1'b0;
			base_start_q <= '0;
			theirs_start_q <= '0;
			theirs_end_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				// end of text: back to the reset state
				offset_q <= '0;
				line_start_q <= 1'b1;
				progress_q <= 3'd0;
				kind_q <= K_START;
				phase_q <= PH_IDLE;
				await_q <= AW_NONE;
				hunk_start_q <= '0;
				ours_start_q <= '0;
				ours_end_q <= '0;
				has_base_q <= 1'b0;
				base_start_q <= '0;
				theirs_start_q <= '0;
				theirs_end_q <= '0;
			end else begin
				offset_q <= n_offset;
				line_start_q <= n_line_start;
				progress_q <= n_progress;
				kind_q <= n_kind;
				phase_q <= n_phase;
				await_q <= n_await;
				hunk_start_q <= n_hunk_start;
				ours_start_q <= n_ours_start;
				ours_end_q <= n_ours_end;
				has_base_q <= n_has_base;
				base_start_q <= n_base_start;
				theirs_start_q <= n_theirs_start;
				theirs_end_q <= n_theirs_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || hunk_out.ready) begin
			out_valid_q <= advance && emit;
		end
	end

	// record fields come from the updated hunk state of the completing byte
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			r_hunk_start_q <= to_out(hunk_start_q);
			r_hunk_end_q <= to_out(nxt_ofs);
			r_ours_start_q <= to_out(n_ours_start);
			r_ours_end_q <= to_out(n_ours_end);
			r_has_base_q <= n_has_base;
			r_base_start_q <= n_has_base ? to_out(n_base_start) : '0;
			r_base_end_q <= n_has_base ? to_out(n_theirs_start - OFS_SEP_LINE) : '0;
			r_theirs_start_q <= to_out(n_theirs_start);
			r_theirs_end_q <= to_out(n_theirs_end);
		end
	end

	assign hunk_out.valid = out_valid_q;
	assign hunk_out.hunk_start = r_hunk_start_q;
	assign hunk_out.hunk_end = r_hunk_end_q;
	assign hunk_out.ours_start = r_ours_start_q;
	assign hunk_out.ours_end = r_ours_end_q;
	assign hunk_out.has_base = r_has_base_q;
	assign hunk_out.base_start = r_base_start_q;
	assign hunk_out.base_end = r_base_end_q;
	assign hunk_out.theirs_start = r_theirs_start_q;
	assign hunk_out.theirs_end = r_theirs_end_q;

endmodule

FILE: test/tb.sv
// testbench for merge_conflict_hunk_scanner: directed texts from a table, then random texts,
// checked by an in-bench scanner, or for typed table rows against the record in the table
// depends on mchs_pkg and the channel interfaces in mchs_ifs.sv

module tb;
	import mchs_pkg::*;

	localparam int OFS_W = 16;
	localparam logic [63:0] OFS_TOP = (64'd1 << OFS_W) - 64'd1;
	localparam int HALF_PERIOD = 10;
	localparam int HOLD_CYC = 300;
	localparam int RAND_BYTES = 1500;
	localparam logic [7:0] TAB_CH = 8'h09;
	localparam logic [7:0] LC_A = 8'h61;
	localparam logic [7:0] LC_Z = 8'h7A;

	// one hunk record, field 0 first: hunk_start .. theirs_end
	typedef logic [0:8][31:0] rec_t;

	typedef struct {
		string txt;
		bit    lst;
		bit    typed;
		bit    has_rec;
		rec_t  rec;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mchs_in_if text_if();
	mchs_out_if hunk_if();

	merge_conflict_hunk_scanner #(.OFFSET_BITS(OFS_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_if),
		.hunk_out(hunk_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	string fld_name [9] = '{"hunk_start", "hunk_end", "ours_start", "ours_end", "has_base",
		"base_start", "base_end", "theirs_start", "theirs_end"};

	rec_t hunk_q[$];
	logic [7:0] txt_buf[$];
	dir_row_t dir_tab[$];

	int n_err = 0;
	int n_bytes = 0;
	int n_texts = 0;
	int n_checked = 0;
	int n_base = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;
	bit hold_on = 1'b0;

	// scanner state
	logic [63:0] ofs;
	bit          at_ls;
	int unsigned prog;
	mark_kind_t  kind;
	logic [7:0]  want_ch;
	phase_t      ph;
	await_t      aw;
	logic [63:0] s_hunk, s_ours_s, s_ours_e, s_base_s, s_theirs_s, s_theirs_e;
	bit          s_has_base;

	function automatic void scan_clear();
		ofs = '0;
		at_ls = 1'b1;
		prog = 0;
		kind = K_START;
		want_ch = CH_START;
		ph = PH_IDLE;
		aw = AW_NONE;
		s_hunk = '0;
		s_ours_s = '0;
		s_ours_e = '0;
		s_base_s = '0;
		s_theirs_s = '0;
		s_theirs_e = '0;
		s_has_base = 1'b0;
	endfunction

	// advance the scanner by one byte; returns 1 when a hunk record completes
	function automatic bit scan_byte(input logic [7:0] b, input bit lst, output rec_t rec);
		logic [63:0] cur, nxt, mpos, bst, bnd;
		bit hit, found;
		cur = ofs;
		nxt = (cur >= OFS_TOP) ? OFS_TOP : cur + 64'd1;
		mpos = cur - 64'd7;
		hit = 1'b0;
		found = 1'b0;
		rec = '0;

		if (at_ls) begin
			prog = 0;
			case (b)
				CH_START: begin kind = K_START; want_ch = b; prog = 1; end
				CH_BASE: begin kind = K_BASE; want_ch = b; prog = 1; end
				CH_SEP: begin kind = K_SEP; want_ch = b; prog = 1; end
				CH_END: begin kind = K_END; want_ch = b; prog = 1; end
				default: ;
			endcase
		end else if (prog >= 1 && prog <= 6) begin
			prog = (b == want_ch) ? prog + 1 : 0;
		end else if (prog == 7) begin
			// separator ends on the newline, the others on a space
			hit = (kind == K_SEP) ? (b == CH_NL) : (b == CH_SP);
			prog = 0;
		end else begin
			prog = 0;
		end

		if (hit) begin
			case (kind)
				K_START: begin
					s_hunk = mpos;
					s_has_base = 1'b0;
					s_base_s = '0;
					ph = PH_OURS;
					aw = AW_START;
				end
				K_BASE: begin
					if (ph == PH_OURS) begin
						s_ours_e = mpos;
						s_has_base = 1'b1;
						ph = PH_BASE;
						aw = AW_BASE;
					end
				end
				K_SEP: begin
					if (ph == PH_OURS || ph == PH_BASE) begin
						if (ph == PH_OURS) s_ours_e = mpos;
						s_theirs_s = nxt;
						ph = PH_THEIRS;
					end
				end
				K_END: begin
					if (ph == PH_THEIRS) begin
						s_theirs_e = mpos;
						aw = AW_END;
					end
				end
				default: ;
			endcase
		end

		if (b == CH_NL) begin
			if (aw == AW_START) begin
				s_ours_s = nxt;
				aw = AW_NONE;
			end else if (aw == AW_BASE) begin
				s_base_s = nxt;
				aw = AW_NONE;
			end
		end
		if (aw == AW_END && (b == CH_NL || lst)) begin
			bst = s_has_base ? s_base_s : 64'd0;
			bnd = s_has_base ? s_theirs_s - 64'd8 : 64'd0;
			rec = {s_hunk[31:0], nxt[31:0], s_ours_s[31:0], s_ours_e[31:0],
				{31'd0, s_has_base}, bst[31:0], bnd[31:0], s_theirs_s[31:0], s_theirs_e[31:0]};
			found = 1'b1;
			ph = PH_IDLE;
			aw = AW_NONE;
		end

		ofs = nxt;
		at_ls = (b == CH_NL);
		if (lst) scan_clear();
		return found;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] marker_ch();
		case ($urandom_range(0, 3))
			0: return CH_START;
			1: return CH_BASE;
			2: return CH_SEP;
			default: return CH_END;
		endcase
	endfunction

	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 8'($urandom_range(LC_A, LC_Z));
		if (r < 70) return CH_SP;
		if (r < 80) return marker_ch();
		if (r < 84) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		txt_buf.insert(txt_buf.size(), b);
	endfunction

	function automatic void add_row(input string t, input bit l, input bit ty, input bit hr,
		input rec_t rc);
		dir_row_t row;
		row.txt = t;
		row.lst = l;
		row.typed = ty;
		row.has_rec = hr;
		row.rec = rc;
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endfunction

	function automatic void put_body(input int unsigned nlines);
		repeat (nlines) begin
			repeat ($urandom_range(0, 12)) put_byte(text_char());
			put_byte(CH_NL);
		end
	endfunction

	// marker line; a spoiled one has a wrong run length or a wrong terminator
	function automatic void put_marker(input logic [7:0] ch, input bit spoil);
		int unsigned n;
		n = 7;
		if (spoil && $urandom_range(0, 1)) n = $urandom_range(0, 1) ? 6 : 8;
		repeat (n) put_byte(ch);
		if (spoil && n == 7) put_byte(ch == CH_SEP ? CH_SP : TAB_CH);
		else if (ch != CH_SEP) put_byte(CH_SP);
		if (ch != CH_SEP || spoil)
			repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(LC_A, LC_Z)));
		put_byte(CH_NL);
	endfunction

	// mostly well formed hunks with random content, some flawed, some pure noise
	function automatic void gen_text();
		int unsigned flaw, r;
		txt_buf.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(10, 80)) begin
				r = $urandom_range(0, 3);
				put_byte(r == 0 ? CH_NL : (r == 1 ? marker_ch() : text_char()));
			end
			return;
		end
		put_body($urandom_range(0, 2));
		repeat ($urandom_range(1, 3)) begin
			flaw = $urandom_range(0, 11);
			put_marker(CH_START, flaw == 6);
			put_body($urandom_range(0, 2));
			if (flaw == 0) begin
				put_marker(CH_START, 1'b0);
				put_body(1);
			end
			if (flaw == 1) put_marker(CH_END, 1'b0);
			if ($urandom_range(0, 1)) begin
				put_marker(CH_BASE, 1'b0);
				put_body($urandom_range(0, 2));
				if (flaw == 2) put_marker(CH_BASE, 1'b0);
			end
			if (flaw != 3) put_marker(CH_SEP, flaw == 7);
			if (flaw == 4) put_marker(CH_BASE, 1'b0);
			put_body($urandom_range(0, 2));
			put_marker(CH_END, flaw == 5);
			put_body($urandom_range(0, 1));
		end
		// sometimes cut the text mid-line
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) if (txt_buf.size() > 1) void'(txt_buf.pop_back());
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit lst, input bit use_model);
		int unsigned g;
		rec_t r;
		if (burst_left != 0) begin
			burst_left--;
			g = 0;
		end else begin
			g = pick_gap();
			if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(30, 120);
		end
		if (g != 0) begin
			text_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= b;
		text_if.last_byte <= lst;
		do @(posedge clk); while (text_if.ready !== 1'b1);
		n_bytes++;
		if (scan_byte(b, lst, r) && use_model) hunk_q.insert(hunk_q.size(), r);
	endtask

	task automatic send_text();
		for (int i = 0; i < txt_buf.size(); i++)
			push_byte(txt_buf[i], i == txt_buf.size() - 1, 1'b1);
		n_texts++;
	endtask

	task automatic wait_drain();
		text_if.valid <= 1'b0;
		while (hunk_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// record sink with random stalls and one long hold-off on request
	initial begin
		int unsigned g;
		hunk_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_on = 1'b1;
				hunk_if.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
				hold_on = 1'b0;
			end else begin
				g = pick_gap();
				if (g != 0) begin
					hunk_if.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			hunk_if.ready <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 6))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		rec_t got, want;
		if (hunk_if.valid === 1'b1 && hunk_if.ready === 1'b1) begin
			got = {hunk_if.hunk_start, hunk_if.hunk_end, hunk_if.ours_start, hunk_if.ours_end,
				{31'd0, hunk_if.has_base}, hunk_if.base_start, hunk_if.base_end,
				hunk_if.theirs_start, hunk_if.theirs_end};
			if (hunk_q.size() == 0) begin
				n_err++;
				$error("hunk record transfer with no record expected");
			end else begin
				want = hunk_q.pop_front();
				n_checked++;
				if (got[4] == 32'd1) n_base++;
				for (int i = 0; i < 9; i++)
					if (got[i] !== want[i]) begin
						n_err++;
						$error("%s: expected %0d, got %0d", fld_name[i], want[i], got[i]);
					end
			end
		end
	end

	initial begin
		int rand_from;
		arst_n = 1'b0;
		text_if.valid <= 1'b0;
		text_if.text_byte <= 8'h00;
		text_if.last_byte <= 1'b0;
		scan_clear();

		// directed texts; rows marked typed carry their record inline
		add_row("<<<<<<< \n=======\n>>>>>>> ", 1'b1, 1'b1, 1'b1,
			{32'd0, 32'd25, 32'd9, 32'd9, 32'd0, 32'd0, 32'd0, 32'd17, 32'd17});
		add_row("<<<<<<< ours\na\n||||||| base\nb\n=======\nc\n>>>>>>> theirs\n",
			1'b1, 1'b0, 1'b0, '0);
		// separator, end and base outside any hunk
		add_row("=======\n>>>>>>> x\n||||||| y\n", 1'b0, 1'b1, 1'b0, '0);
		// end before separator, second base, base after separator
		add_row({"<<<<<<< a\n>>>>>>> early\n||||||| b1\n||||||| b2\n=======\n",
			"||||||| late\n>>>>>>> z\n"}, 1'b0, 1'b0, 1'b0, '0);
		// fresh start marker drops the open hunk
		add_row("<<<<<<< a\nx\n<<<<<<< b\ny\n=======\n>>>>>>> c\n", 1'b1, 1'b0, 1'b0, '0);
		add_row("<<<<<<< a\n=======\nfoo", 1'b1, 1'b1, 1'b0, '0);
		add_row("<<<<<<< \n=======", 1'b1, 1'b1, 1'b0, '0);
		// near misses: short and long runs, wrong terminators, marker mid-line
		add_row("<<<<<< x\n<<<<<<<<\n<<<<<<<\tx\n=======x\n=======\r\n a<<<<<<< \n\n",
			1'b0, 1'b0, 1'b0, '0);
		add_row("<<<<<<< \n||||||| \n=======\n>>>>>>> x", 1'b1, 1'b0, 1'b0, '0);
		add_row("\n", 1'b1, 1'b1, 1'b0, '0);
		add_row("\377", 1'b1, 1'b1, 1'b0, '0);
		add_row(">>>>>>> x\n<<<<<<<  \n=======\n=======\n>>>>>>> \n>>>>>>> \n",
			1'b1, 1'b0, 1'b0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			for (int j = 0; j < dir_tab[i].txt.len(); j++)
				push_byte(dir_tab[i].txt[j], dir_tab[i].lst && j == dir_tab[i].txt.len() - 1,
					!dir_tab[i].typed);
			if (dir_tab[i].typed && dir_tab[i].has_rec)
				hunk_q.insert(hunk_q.size(), dir_tab[i].rec);
			if (dir_tab[i].lst) n_texts++;
		end
		wait_drain();

		rand_from = n_bytes;
		while (n_bytes - rand_from < RAND_BYTES) begin
			if (n_texts % 7 == 4) begin
				// sink holds off while back-to-back hunks pile up behind the output register
				hold_req = 1'b1;
				text_if.valid <= 1'b0;
				@(posedge clk);
				while (!hold_on) @(posedge clk);
				txt_buf.delete();
				repeat (3) put_str("<<<<<<< \n=======\n>>>>>>> \n");
			end else begin
				gen_text();
			end
			send_text();
			if (n_texts % 6 == 0) wait_drain();
		end
		wait_drain();
		repeat (8) @(posedge clk);

		$display("scanned %0d bytes in %0d texts, offsets %0d bits wide", n_bytes, n_texts,
			OFS_W);
		$display("checked %0d hunk records, %0d with a base section", n_checked, n_base);
		if (n_err == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/mchs_pkg.sv
rtl/core/mchs_ifs.sv
rtl/core/merge_conflict_hunk_scanner.sv
test/tb.sv
